// ===== hdl/ut_iir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut_iir_pkg
// Shared types and constants of the uniform-tap direct form 1 IIR filter.
// ----------------------------------------------------------------------------
package ut_iir_pkg;

  // history rings sized for the largest tap count
  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = 6;
  localparam logic [PTR_W-1:0] FILL_MAX = PTR_W'(RING_DEPTH - 1);

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int Y_W      = 24;
  localparam int ISUM_W   = 22;
  localparam int OSUM_W   = 30;
  localparam int WIN_W    = ISUM_W + 1;
  localparam int FFP_W    = GAIN_W + WIN_W;
  localparam int FBP_W    = GAIN_W + OSUM_W;
  localparam int ACC_W    = FBP_W + 1;
  localparam int FRAC_W   = 14;
  localparam int SHR_W    = ACC_W - FRAC_W;

  localparam logic signed [Y_W-1:0] Y_MAX = 24'sh7FFFFF;
  localparam logic signed [Y_W-1:0] Y_MIN = 24'sh800000;

  // register map (index taken from paddr bit 2)
  localparam logic REG_FF_GAIN = 1'b0;
  localparam logic REG_FB_GAIN = 1'b1;
  localparam logic signed [GAIN_W-1:0] FF_GAIN_RST = 16'sd16384;
  localparam logic signed [GAIN_W-1:0] FB_GAIN_RST = 16'sd0;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;
  } in_item_t;

  typedef struct packed {
    logic signed [Y_W-1:0] filtered;
    logic                  clipped;
  } out_item_t;

  // feedforward stage result handed to the feedback stage
  typedef struct packed {
    logic                    valid;
    logic                    start;
    logic [PTR_W-1:0]        ptr;
    logic                    out_ok;
    logic signed [FFP_W-1:0] ff_prod;
  } ff_stage_t;

  // look-ahead from the first stage for the output ring read
  typedef struct packed {
    logic             busy;
    logic [PTR_W-1:0] fb_addr;
  } s1_look_t;

endpackage

// ===== hdl/uniform_tap_iir_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_tap_iir_filter_unit
// Direct form 1 IIR filter with one shared feedforward gain and one shared
// feedback gain, running window sums over ring memories, APB gain registers.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while src_stall is low; the feedback loop
// (multiply, subtract, saturate, accumulate in one stage) sets the clock
// period. A sample passes the first-stage and feedforward stage registers.
// Reset: synchronous; empties the pipeline and queue, zeroes sums, pointer
// and fill count (history reads as zero until rewritten), gains to defaults.
// ----------------------------------------------------------------------------
module uniform_tap_iir_filter_unit #(
  parameter int FF_TAPS = 8,
  parameter int FB_TAPS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // sample channel
  input  logic                   src_valid,
  output logic                   src_stall,
  input  ut_iir_pkg::in_item_t   src_data,
  // result channel
  output logic                   res_valid,
  input  logic                   res_stall,
  output ut_iir_pkg::out_item_t  res_data,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic signed [ut_iir_pkg::GAIN_W-1:0] ff_gain, fb_gain;
  logic                                 accept, cfg_wr, res_wr;
  ut_iir_pkg::s1_look_t                 look;
  ut_iir_pkg::ff_stage_t                stage;
  ut_iir_pkg::out_item_t                res_item;
  logic [ut_iir_pkg::OQ_CW-1:0]         level, committed;

  // gain registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_gain <= ut_iir_pkg::FF_GAIN_RST;
      fb_gain <= ut_iir_pkg::FB_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ut_iir_pkg::REG_FF_GAIN: ff_gain <= pwdata[ut_iir_pkg::GAIN_W-1:0];
        ut_iir_pkg::REG_FB_GAIN: fb_gain <= pwdata[ut_iir_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ut_iir_pkg::REG_FF_GAIN: prdata = 32'(ff_gain);
      ut_iir_pkg::REG_FB_GAIN: prdata = 32'(fb_gain);
      default:                 prdata = '0;
    endcase
  end

  // queue slots reserved by queued and in-flight items
  assign committed = level + ut_iir_pkg::OQ_CW'(look.busy)
                   + ut_iir_pkg::OQ_CW'(stage.valid);
  assign src_stall = (committed >= ut_iir_pkg::OQ_CW'(ut_iir_pkg::OQ_DEPTH));
  assign accept    = src_valid && !src_stall;

  ut_iir_ff #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) u_ff (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (src_data),
    .ff_gain (ff_gain),
    .look    (look),
    .stage   (stage)
  );

  ut_iir_fb #(
    .FB_TAPS (FB_TAPS)
  ) u_fb (
    .clk      (clk),
    .rst      (rst),
    .fb_gain  (fb_gain),
    .look     (look),
    .stage    (stage),
    .res_wr   (res_wr),
    .res_item (res_item)
  );

  ut_iir_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_wr),
    .wr_item  (res_item),
    .rd_valid (res_valid),
    .rd_stall (res_stall),
    .rd_item  (res_data),
    .level    (level)
  );

endmodule

// ===== hdl/ut_iir_ff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut_iir_ff
// Front end: input history ring, ring pointer and fill count, running input
// window sum and the feedforward product.
// ----------------------------------------------------------------------------
module ut_iir_ff #(
  parameter int FF_TAPS = 8,
  parameter int FB_TAPS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    accept,
  input  ut_iir_pkg::in_item_t                    item,
  input  logic signed [ut_iir_pkg::GAIN_W-1:0]    ff_gain,
  output ut_iir_pkg::s1_look_t                    look,
  output ut_iir_pkg::ff_stage_t                   stage
);

  localparam int PW = ut_iir_pkg::PTR_W;
  localparam logic [PW-1:0] FF_OFS = PW'(FF_TAPS - 1);
  localparam logic [PW-1:0] FB_OFS = PW'(FB_TAPS - 1);
  localparam bit FF_SINGLE = (FF_TAPS == 1);

  // input history ring
  logic signed [ut_iir_pkg::SAMPLE_W-1:0] in_mem [ut_iir_pkg::RING_DEPTH];
  logic signed [ut_iir_pkg::SAMPLE_W-1:0] rd_q;

  // ring control
  logic [PW-1:0] ptr, fill;
  logic [PW-1:0] p_eff, fill_eff, rd_addr;

  // first stage registers
  logic                                   s1_valid, s1_start, s1_in_ok, s1_out_ok;
  logic signed [ut_iir_pkg::SAMPLE_W-1:0] s1_sample;
  logic [PW-1:0]                          s1_ptr, s1_fb_addr;

  // window sum arithmetic
  logic signed [ut_iir_pkg::ISUM_W-1:0] isum, isum_eff, isum_next, drop_x;
  logic signed [ut_iir_pkg::WIN_W-1:0]  win_sum;
  logic signed [ut_iir_pkg::FFP_W-1:0]  prod;

  // a start request restarts the ring at entry zero with nothing valid
  always_comb begin
    p_eff    = item.start_req ? '0 : ptr;
    fill_eff = item.start_req ? '0 : fill;
    rd_addr  = p_eff - FF_OFS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else if (accept) begin
      ptr  <= p_eff + 1'b1;
      fill <= (fill_eff == ut_iir_pkg::FILL_MAX) ? fill_eff : fill_eff + 1'b1;
    end
  end

  // ring write of the new sample and read of the one leaving the window
  always_ff @(posedge clk) begin
    if (accept) begin
      in_mem[p_eff] <= item.sample;
    end
    rd_q <= in_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_start   <= item.start_req;
    s1_sample  <= item.sample;
    s1_ptr     <= p_eff;
    s1_fb_addr <= p_eff - FB_OFS;
    s1_in_ok   <= (fill_eff >= FF_OFS);
    s1_out_ok  <= (fill_eff >= FB_OFS);
  end

  // running input sum and feedforward product
  always_comb begin
    isum_eff = s1_start ? '0 : isum;
    if (FF_SINGLE) begin
      drop_x = ut_iir_pkg::ISUM_W'(s1_sample);
    end else if (s1_in_ok) begin
      drop_x = ut_iir_pkg::ISUM_W'(rd_q);
    end else begin
      drop_x = '0;
    end
    win_sum   = ut_iir_pkg::WIN_W'(isum_eff) + ut_iir_pkg::WIN_W'(s1_sample);
    isum_next = isum_eff + ut_iir_pkg::ISUM_W'(s1_sample) - drop_x;
    prod      = ut_iir_pkg::FFP_W'(ff_gain) * ut_iir_pkg::FFP_W'(win_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      isum        <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        isum <= isum_next;
      end
      stage.valid <= s1_valid;
    end
    stage.start   <= s1_start;
    stage.ptr     <= s1_ptr;
    stage.out_ok  <= s1_out_ok;
    stage.ff_prod <= prod;
  end

  assign look.busy    = s1_valid;
  assign look.fb_addr = s1_fb_addr;

endmodule

// ===== hdl/ut_iir_fb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut_iir_fb
// Feedback stage: output history ring with bypass, running output window sum,
// feedback product, scaling and saturation.
// ----------------------------------------------------------------------------
module ut_iir_fb #(
  parameter int FB_TAPS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [ut_iir_pkg::GAIN_W-1:0] fb_gain,
  input  ut_iir_pkg::s1_look_t                 look,
  input  ut_iir_pkg::ff_stage_t                stage,
  output logic                                 res_wr,
  output ut_iir_pkg::out_item_t                res_item
);

  localparam bit FB_SINGLE = (FB_TAPS == 1);

  // output history ring
  logic signed [ut_iir_pkg::Y_W-1:0] out_mem [ut_iir_pkg::RING_DEPTH];
  logic signed [ut_iir_pkg::Y_W-1:0] rd_q, fwd_y_q, drop_mem;
  logic                              fwd_q;

  logic signed [ut_iir_pkg::OSUM_W-1:0] osum, osum_eff, osum_next, drop_y;
  logic signed [ut_iir_pkg::FBP_W-1:0]  fb_prod;
  logic signed [ut_iir_pkg::ACC_W-1:0]  acc;
  logic signed [ut_iir_pkg::SHR_W-1:0]  shr;
  logic signed [ut_iir_pkg::Y_W-1:0]    y;
  logic                                 clip;

  // scale, subtract, floor shift and saturate
  always_comb begin
    osum_eff = stage.start ? '0 : osum;
    fb_prod  = ut_iir_pkg::FBP_W'(fb_gain) * ut_iir_pkg::FBP_W'(osum_eff);
    acc      = ut_iir_pkg::ACC_W'(stage.ff_prod) - ut_iir_pkg::ACC_W'(fb_prod);
    shr      = acc[ut_iir_pkg::ACC_W-1:ut_iir_pkg::FRAC_W];
    if (shr > ut_iir_pkg::SHR_W'(ut_iir_pkg::Y_MAX)) begin
      y    = ut_iir_pkg::Y_MAX;
      clip = 1'b1;
    end else if (shr < ut_iir_pkg::SHR_W'(ut_iir_pkg::Y_MIN)) begin
      y    = ut_iir_pkg::Y_MIN;
      clip = 1'b1;
    end else begin
      y    = shr[ut_iir_pkg::Y_W-1:0];
      clip = 1'b0;
    end
  end

  // ring write of the new output and read for the next item's window drop
  always_ff @(posedge clk) begin
    if (stage.valid) begin
      out_mem[stage.ptr] <= y;
    end
    rd_q <= out_mem[look.fb_addr];
  end

  // bypass when the entry is being written by the item ahead in this cycle
  always_ff @(posedge clk) begin
    fwd_q   <= stage.valid && (stage.ptr == look.fb_addr);
    fwd_y_q <= y;
  end

  assign drop_mem = fwd_q ? fwd_y_q : rd_q;

  // running output sum
  always_comb begin
    if (FB_SINGLE) begin
      drop_y = ut_iir_pkg::OSUM_W'(y);
    end else if (stage.out_ok) begin
      drop_y = ut_iir_pkg::OSUM_W'(drop_mem);
    end else begin
      drop_y = '0;
    end
    osum_next = osum_eff + ut_iir_pkg::OSUM_W'(y) - drop_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osum <= '0;
    end else if (stage.valid) begin
      osum <= osum_next;
    end
  end

  assign res_wr            = stage.valid;
  assign res_item.filtered = y;
  assign res_item.clipped  = clip;

endmodule

// ===== hdl/ut_iir_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut_iir_outq
// Small result queue that decouples the filter pipeline from the consumer.
// ----------------------------------------------------------------------------
module ut_iir_outq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  ut_iir_pkg::out_item_t          wr_item,
  output logic                           rd_valid,
  input  logic                           rd_stall,
  output ut_iir_pkg::out_item_t          rd_item,
  output logic [ut_iir_pkg::OQ_CW-1:0]   level
);

  ut_iir_pkg::out_item_t             q_mem [ut_iir_pkg::OQ_DEPTH];
  logic [ut_iir_pkg::OQ_AW-1:0]      wr_ptr, rd_ptr;
  logic [ut_iir_pkg::OQ_CW-1:0]      count;
  logic                              pop;

  assign rd_valid = (count != '0);
  assign pop      = rd_valid && !rd_stall;
  assign rd_item  = q_mem[rd_ptr];
  assign level    = count;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr] <= wr_item;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ut_iir_pkg::OQ_CW'(wr_en) - ut_iir_pkg::OQ_CW'(pop);
    end
  end

endmodule

// ===== hdl/ut_iir_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut_iir_chk
// Port-level checks for the uniform-tap IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module ut_iir_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  src_stall,
  input logic                  res_valid,
  input logic                  res_stall,
  input ut_iir_pkg::out_item_t res_data
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed or dropped");

  // a clipped result sits on one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.clipped |->
      (res_data.filtered == ut_iir_pkg::Y_MAX) ||
      (res_data.filtered == ut_iir_pkg::Y_MIN))
    else $error("clipped flag without saturated value");

  // reset leaves no result pending and the input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !src_stall)
    else $error("pipeline not empty after reset");

  // a result only leaves by a transfer
  a_res_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(res_valid) |-> $past(rst) || $past(!res_stall))
    else $error("result withdrawn without transfer");

endmodule

bind uniform_tap_iir_filter_unit ut_iir_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

// ===== dv/uniform_tap_iir_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_tap_iir_filter_unit_tb
// Self-checking bench for the equal-tap direct form 1 IIR filter. A local
// fixed-point filter computes each expected output when its sample transfers.
// Outputs are compared in order. Gains are written over the register port and
// read back. Directed cases come first, then random streams under three idle
// mixes, then a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module uniform_tap_iir_filter_unit_tb;

  localparam int FF_TAPS        = 8;
  localparam int FB_TAPS        = 8;
  localparam int RESULT_LATENCY = 3;
  localparam int ITEMS_PER_GAIN = 100;
  localparam int HOLD_CYCLES    = 200;
  localparam int RUN_LIMIT_NS   = 5_000_000;

  localparam logic [2:0] ADDR_FF_GAIN = {ut_iir_pkg::REG_FF_GAIN, 2'b00};
  localparam logic [2:0] ADDR_FB_GAIN = {ut_iir_pkg::REG_FB_GAIN, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  src_valid;
  logic                  src_stall;
  ut_iir_pkg::in_item_t  src_data;
  logic                  res_valid;
  logic                  res_stall;
  ut_iir_pkg::out_item_t res_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // predictor state
  logic signed [ut_iir_pkg::GAIN_W-1:0]   ff_gain_q;
  logic signed [ut_iir_pkg::GAIN_W-1:0]   fb_gain_q;
  logic signed [ut_iir_pkg::SAMPLE_W-1:0] in_ring  [ut_iir_pkg::RING_DEPTH];
  logic signed [ut_iir_pkg::Y_W-1:0]      out_ring [ut_iir_pkg::RING_DEPTH];
  logic signed [ut_iir_pkg::ISUM_W-1:0]   in_window;
  logic signed [ut_iir_pkg::OSUM_W-1:0]   out_window;
  logic [ut_iir_pkg::PTR_W-1:0]           ring_ptr;

  ut_iir_pkg::out_item_t expected_outputs [$];
  int                    mismatches;
  int                    sender_idle_pct;
  int                    recv_idle_pct;
  int                    hold_req;
  int                    hold_left;

  uniform_tap_iir_filter_unit #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("[uniform_tap_iir_filter_unit] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch in %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // clear histories, sums and pointer, as on reset or start
  task automatic clear_filter_state();
    for (int i = 0; i < ut_iir_pkg::RING_DEPTH; i++) begin
      in_ring[i]  = '0;
      out_ring[i] = '0;
    end
    in_window  = '0;
    out_window = '0;
    ring_ptr   = '0;
  endtask

  // one filter step: expected output for a sample, then update histories
  task automatic filter_step(input ut_iir_pkg::in_item_t item,
                             output ut_iir_pkg::out_item_t res);
    longint                                 acc;
    longint                                 y;
    logic signed [ut_iir_pkg::SAMPLE_W-1:0] x;
    logic signed [ut_iir_pkg::Y_W-1:0]      y_sat;
    logic [ut_iir_pkg::PTR_W-1:0]           p;
    logic [ut_iir_pkg::PTR_W-1:0]           drop;
    if (item.start_req)
      clear_filter_state();
    x   = $signed(item.sample);
    p   = ring_ptr;
    acc = longint'(ff_gain_q) * (longint'(in_window) + longint'(x))
        - longint'(fb_gain_q) * longint'(out_window);
    y   = acc >>> ut_iir_pkg::FRAC_W;
    res.clipped = 1'b0;
    if (y > longint'(ut_iir_pkg::Y_MAX)) begin
      y = longint'(ut_iir_pkg::Y_MAX);
      res.clipped = 1'b1;
    end else if (y < longint'(ut_iir_pkg::Y_MIN)) begin
      y = longint'(ut_iir_pkg::Y_MIN);
      res.clipped = 1'b1;
    end
    y_sat = y[ut_iir_pkg::Y_W-1:0];
    res.filtered = y_sat;
    // newest values in, oldest out of each window
    in_ring[p]  = x;
    out_ring[p] = y_sat;
    drop        = p - ut_iir_pkg::PTR_W'(FF_TAPS - 1);
    in_window   = in_window + x - in_ring[drop];
    drop        = p - ut_iir_pkg::PTR_W'(FB_TAPS - 1);
    out_window  = out_window + y_sat - out_ring[drop];
    ring_ptr    = p + 1'b1;
  endtask

  function automatic ut_iir_pkg::in_item_t make_item(
      input logic signed [ut_iir_pkg::SAMPLE_W-1:0] s, input logic st);
    ut_iir_pkg::in_item_t it;
    it.sample    = s;
    it.start_req = st;
    return it;
  endfunction

  // offer one sample, predict on transfer, then maybe idle
  task automatic send_sample(input ut_iir_pkg::in_item_t item);
    ut_iir_pkg::out_item_t res;
    src_valid <= 1'b1;
    src_data  <= item;
    do @(posedge clk); while (src_stall);
    filter_step(item, res);
    expected_outputs.push_back(res);
    if ($urandom_range(99) < sender_idle_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // stop offering and wait until every output has transferred
  task automatic drain_results();
    src_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_gain(input logic [2:0] addr,
                            input logic signed [ut_iir_pkg::GAIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(32-ut_iir_pkg::GAIN_W){value[ut_iir_pkg::GAIN_W-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FF_GAIN)
      ff_gain_q = value;
    else
      fb_gain_q = value;
  endtask

  task automatic check_gain(input logic [2:0] addr,
                            input logic signed [ut_iir_pkg::GAIN_W-1:0] want);
    logic [ut_iir_pkg::GAIN_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata[ut_iir_pkg::GAIN_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch(addr == ADDR_FF_GAIN ? "ff_gain readback" : "fb_gain readback",
                      longint'(want), longint'($signed(got)));
  endtask

  // gains change only with the filter empty
  task automatic set_gains(input logic signed [ut_iir_pkg::GAIN_W-1:0] ff,
                           input logic signed [ut_iir_pkg::GAIN_W-1:0] fb);
    drain_results();
    write_gain(ADDR_FF_GAIN, ff);
    write_gain(ADDR_FB_GAIN, fb);
    check_gain(ADDR_FF_GAIN, ff);
    check_gain(ADDR_FB_GAIN, fb);
  endtask

  task automatic check_reset_values();
    check_gain(ADDR_FF_GAIN, ut_iir_pkg::FF_GAIN_RST);
    check_gain(ADDR_FB_GAIN, ut_iir_pkg::FB_GAIN_RST);
  endtask

  task automatic run_directed_samples();
    sender_idle_pct = 19;
    recv_idle_pct   = 79;
    // unity gain, extremes, window wrap and restart
    send_sample(make_item(16'sh7FFF, 1'b1));
    send_sample(make_item(16'sh8000, 1'b0));
    send_sample(make_item(16'sh0000, 1'b0));
    send_sample(make_item(-16'sd1, 1'b0));
    send_sample(make_item(16'sd1, 1'b0));
    repeat (5) send_sample(make_item(16'sh7FFF, 1'b0));
    send_sample(make_item(16'sd12345, 1'b1));
    // tiny gain: floor of negative fractions
    set_gains(16'sd1, 16'sd0);
    send_sample(make_item(-16'sd1, 1'b1));
    send_sample(make_item(-16'sd1, 1'b0));
    send_sample(make_item(16'sd16383, 1'b0));
    // strong positive feedback drives both saturation limits
    set_gains(16'sh7FFF, 16'sh8000);
    send_sample(make_item(16'sh7FFF, 1'b1));
    repeat (5) send_sample(make_item(16'sh7FFF, 1'b0));
    send_sample(make_item(16'sh8000, 1'b1));
    repeat (5) send_sample(make_item(16'sh8000, 1'b0));
  endtask

  task automatic run_random_stream(input int send_pct, input int recv_pct);
    logic signed [ut_iir_pkg::GAIN_W-1:0] ff;
    logic signed [ut_iir_pkg::GAIN_W-1:0] fb;
    ut_iir_pkg::in_item_t                 item;
    int                                   tone;
    sender_idle_pct = send_pct;
    recv_idle_pct   = recv_pct;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: begin ff = ut_iir_pkg::FF_GAIN_RST; fb = ut_iir_pkg::FB_GAIN_RST; end
        1: begin ff = 16'sh7FFF;   fb = 16'sh8000;   end
        2: begin ff = 16'sh8000;   fb = 16'sh7FFF;   end
        3: begin
          ff = ut_iir_pkg::GAIN_W'($urandom);
          fb = ut_iir_pkg::GAIN_W'($urandom);
        end
        default: begin
          ff = ut_iir_pkg::GAIN_W'($urandom);
          fb = -$signed(ut_iir_pkg::GAIN_W'($urandom_range(4000)));
        end
      endcase
      set_gains(ff, fb);
      tone = 0;
      for (int n = 0; n < ITEMS_PER_GAIN; n++) begin
        if (n % 20 == 0)
          tone = $urandom_range(3);
        // runs of loud same-sign samples push the output toward the limits
        case (tone)
          2:       item.sample = {1'b0, 3'b111, 12'($urandom)};
          3:       item.sample = {1'b1, 3'b000, 12'($urandom)};
          default: begin
            case ($urandom_range(7))
              0:       item.sample = 16'sh7FFF;
              1:       item.sample = 16'sh8000;
              default: item.sample = ut_iir_pkg::SAMPLE_W'($urandom);
            endcase
          end
        endcase
        item.start_req = ($urandom_range(99) < 3);
        send_sample(item);
      end
    end
  endtask

  // receiver holds off long enough to fill the filter and stall its input
  task automatic run_output_hold();
    ut_iir_pkg::in_item_t item;
    set_gains(16'sd9000, -16'sd3000);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_req        = HOLD_CYCLES;
    for (int n = 0; n < 60; n++) begin
      item.sample    = ut_iir_pkg::SAMPLE_W'($urandom);
      item.start_req = (n == 0);
      send_sample(item);
    end
  endtask

  // receiver stall, with a counted long hold on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_outputs
    ut_iir_pkg::out_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch("unexpected output", 0, longint'($signed(res_data.filtered)));
      end else begin
        want = expected_outputs.pop_front();
        if (res_data.filtered !== want.filtered)
          report_mismatch("filtered", longint'(want.filtered),
                          longint'($signed(res_data.filtered)));
        if (res_data.clipped !== want.clipped)
          report_mismatch("clipped", longint'(want.clipped), longint'(res_data.clipped));
      end
    end
  end

  initial begin
    rst             = 1'b1;
    src_valid       = 1'b0;
    src_data        = '0;
    res_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_req        = 0;
    hold_left       = 0;
    ff_gain_q       = ut_iir_pkg::FF_GAIN_RST;
    fb_gain_q       = ut_iir_pkg::FB_GAIN_RST;
    clear_filter_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_reset_values();
    run_directed_samples();
    run_random_stream(19, 79);
    run_random_stream(79, 19);
    run_random_stream(0, 0);
    run_output_hold();

    drain_results();
    if (mismatches == 0)
      $display("[uniform_tap_iir_filter_unit] OK");
    else
      $display("[uniform_tap_iir_filter_unit] ERROR");
    $finish;
  end

endmodule
